[src/gda_pkg.sv]
// gda_pkg: types, constants and calendar helpers for the date-add block.
// No dependencies.
`default_nettype none
package gda_pkg;

   localparam int unsigned YEAR_W  = 14;  // year field width
   localparam int unsigned YCNT_W  = 17;  // running year, holds MAX_YEAR + 1
   localparam int unsigned ADD_W   = 20;  // day count field width
   localparam int unsigned DOY_W   = 21;  // day-of-year accumulator
   localparam int unsigned LEN_W   = 9;   // month or year length

   localparam logic [LEN_W-1:0] YEAR_LEN      = 9'd365;
   localparam logic [LEN_W-1:0] LEAP_YEAR_LEN = 9'd366;
   localparam logic [13:0]      CYCLE_400     = 14'd400;
   localparam logic [8:0]       CYCLE_100     = 9'd100;
   localparam logic [3:0]       MONTH_JAN     = 4'd1;
   localparam logic [3:0]       MONTH_FEB     = 4'd2;
   localparam logic [3:0]       MONTH_APR     = 4'd4;
   localparam logic [3:0]       MONTH_JUN     = 4'd6;
   localparam logic [3:0]       MONTH_SEP     = 4'd9;
   localparam logic [3:0]       MONTH_NOV     = 4'd11;
   localparam logic [3:0]       MONTH_DEC     = 4'd12;

   typedef struct packed {
      logic [4:0]        day;
      logic [3:0]        month;
      logic [YEAR_W-1:0] year;
      logic [ADD_W-1:0]  days_to_add;
   } req_type;

   typedef struct packed {
      logic [4:0]        out_day;
      logic [3:0]        out_month;
      logic [YEAR_W-1:0] out_year;
      logic              input_valid;
      logic              overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD400,
      ST_MOD100,
      ST_CHECK,
      ST_DOY,
      ST_YEARS,
      ST_MONTHS
   } state_type;

   // days in a month; codes outside 1..12 fall to 31
   function automatic logic [LEN_W-1:0] month_len(input logic [3:0] m, input logic leap);
      logic [LEN_W-1:0] len;
      begin
         case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 9'd30;
            MONTH_FEB: len = leap ? 9'd29 : 9'd28;
            default: len = 9'd31;
         endcase
         return len;
      end
   endfunction

endpackage
`default_nettype wire

[src/gregorian_date_add_days.sv]
// gregorian_date_add_days: adds a day count to a Gregorian date.
// Uses gda_pkg (item types, state enum, month length helper).
//
// Sequence: reduce the year mod 400, then mod 100, check the date, add up the
//   months before the start month, then step whole years and then months.
//   One item at a time; busy drops in the cycle that shows the result strobe.
// Throughput is set by the year-stepping loop through the one shared
//   add/subtract/compare unit, one year or month per cycle.
// Reset (synchronous, active high) returns the sequencer to idle and drops
//   the strobe. The result is shown for one cycle; the receiver cannot stall.
`default_nettype none
module gregorian_date_add_days #(
   parameter int unsigned MAX_YEAR = 9999,
   parameter int unsigned ADD_BITS = 20
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire gda_pkg::req_type req_item,
   output logic                 rsp_valid,
   output gda_pkg::rsp_type     rsp_item
);
   import gda_pkg::*;

   // year limit at running-year width
   localparam logic [YCNT_W-1:0] MAX_Y = YCNT_W'(MAX_YEAR);
   // only the low ADD_BITS of the count take part
   localparam logic [ADD_W-1:0] ADD_MASK =
      (ADD_BITS >= ADD_W) ? {ADD_W{1'b1}} : ADD_W'((64'd1 << ADD_BITS) - 64'd1);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [13:0]        rem400_ff, rem400_in;   // year mod 400
   logic [8:0]         rem100_ff, rem100_in;   // year mod 100
   logic [YCNT_W-1:0]  year_ff, year_in;
   logic [3:0]         mon_ff, mon_in;
   logic [DOY_W-1:0]   acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               leap;
   logic [LEN_W-1:0]   opnd;
   logic [DOY_W-1:0]   unit_sum, unit_diff;
   logic               unit_gt;
   logic [YCNT_W-1:0]  year_next;
   logic               date_ok;
   logic [LEN_W-1:0]   in_mlen;

   // leap test from the tracked remainders
   assign leap = ((year_ff[1:0] == 2'd0) && (rem100_ff != 9'd0)) || (rem400_ff == 14'd0);

   // shared arithmetic unit: operand is a month or a year length
   always_comb begin
      if (state_ff == ST_YEARS) begin
         opnd = leap ? LEAP_YEAR_LEN : YEAR_LEN;
      end else begin
         opnd = month_len(mon_ff, leap);
      end
   end
   assign unit_sum  = acc_ff + DOY_W'(opnd);
   assign unit_diff = acc_ff - DOY_W'(opnd);
   assign unit_gt   = acc_ff > DOY_W'(opnd);

   assign year_next = year_ff + YCNT_W'(1);
   assign in_mlen   = month_len(req_ff.month, leap);
   assign date_ok   = (req_ff.month >= MONTH_JAN) && (req_ff.month <= MONTH_DEC) &&
                      (req_ff.year != '0) && (YCNT_W'(req_ff.year) <= MAX_Y) &&
                      (req_ff.day != 5'd0) && (LEN_W'(req_ff.day) <= in_mlen);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_MOD400;
         end
         ST_MOD400: begin
            if (rem400_ff < CYCLE_400) state_in = ST_MOD100;
         end
         ST_MOD100: begin
            if (rem100_ff < CYCLE_100) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = date_ok ? ST_DOY : ST_IDLE;
         end
         ST_DOY: begin
            if (mon_ff >= req_ff.month) state_in = ST_YEARS;
         end
         ST_YEARS: begin
            if (!unit_gt) state_in = ST_MONTHS;
            else if (year_next > MAX_Y) state_in = ST_IDLE;
         end
         ST_MONTHS: begin
            if (!((mon_ff < MONTH_DEC) && unit_gt)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      req_in       = req_ff;
      rem400_in    = rem400_ff;
      rem100_in    = rem100_ff;
      year_in      = year_ff;
      mon_in       = mon_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in    = req_item;
               rem400_in = req_item.year;
               year_in   = YCNT_W'(req_item.year);
            end
         end
         ST_MOD400: begin
            if (rem400_ff >= CYCLE_400) begin
               rem400_in = rem400_ff - CYCLE_400;
            end else begin
               rem100_in = rem400_ff[8:0];
            end
         end
         ST_MOD100: begin
            if (rem100_ff >= CYCLE_100) rem100_in = rem100_ff - CYCLE_100;
         end
         ST_CHECK: begin
            acc_in = DOY_W'(req_ff.day) + DOY_W'(req_ff.days_to_add & ADD_MASK);
            mon_in = MONTH_JAN;
            if (!date_ok) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
            end
         end
         ST_DOY: begin
            // add lengths of the months before the start month
            if (mon_ff < req_ff.month) begin
               acc_in = unit_sum;
               mon_in = mon_ff + 4'd1;
            end else begin
               mon_in = MONTH_JAN;
            end
         end
         ST_YEARS: begin
            if (unit_gt) begin
               acc_in    = unit_diff;
               year_in   = year_next;
               rem400_in = (rem400_ff == 14'd399) ? 14'd0 : rem400_ff + 14'd1;
               rem100_in = (rem100_ff == 9'd99) ? 9'd0 : rem100_ff + 9'd1;
               if (year_next > MAX_Y) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in            = '0;
                  rsp_in.input_valid = 1'b1;
                  rsp_in.overflow    = 1'b1;
               end
            end
         end
         ST_MONTHS: begin
            if ((mon_ff < MONTH_DEC) && unit_gt) begin
               acc_in = unit_diff;
               mon_in = mon_ff + 4'd1;
            end else begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_day     = acc_ff[4:0];
               rsp_in.out_month   = mon_ff;
               rsp_in.out_year    = year_ff[YEAR_W-1:0];
               rsp_in.input_valid = 1'b1;
               rsp_in.overflow    = 1'b0;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rem400_ff <= rem400_in;
      rem100_ff <= rem100_in;
      year_ff   <= year_in;
      mon_ff    <= mon_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

[dv/gregorian_date_add_days_test.sv]
// gregorian_date_add_days_test: self-checking bench for the date-add block.
// Drives start/busy items, predicts every result and checks each strobe.
// Depends on gda_pkg and gregorian_date_add_days only.
module gregorian_date_add_days_test;
   import gda_pkg::*;

   localparam int unsigned MAX_YEAR = 9999;
   localparam int unsigned ADD_BITS = 20;
   // Bound on the slowest legal run: 170 items (141 are sent), each with its full
   // year stepping and the longest sender gap, taken four times over.
   localparam int unsigned CYCLE_LIMIT = 170 * (3000 + 11) * 4;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned REQ_W = $bits(req_type);

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   // results still owed by the block, oldest first
   rsp_type     later_dates[$];
   int unsigned mismatch_count;
   int unsigned error_count;

   gregorian_date_add_days #(
      .MAX_YEAR(MAX_YEAR),
      .ADD_BITS(ADD_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Calendar predictor
   // ---------------------------------------------------------------------
   // Gregorian rule: every 4th year, except centuries, except every 4th century.
   function automatic bit is_leap(input int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic int unsigned days_in_month(input logic [3:0] mo, input int unsigned yr);
      case (mo)
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
         MONTH_FEB: return is_leap(yr) ? 29 : 28;
         default: return 31;
      endcase
   endfunction

   function automatic int unsigned days_in_year(input int unsigned yr);
      return is_leap(yr) ? int'(LEAP_YEAR_LEN) : int'(YEAR_LEN);
   endfunction

   // Date that lies days_to_add days after the start date, or a flagged zero.
   function automatic rsp_type predict_later_date(input req_type r);
      rsp_type     res;
      int unsigned yr;
      int unsigned doy;
      logic [3:0]  mo;
      res = '0;
      yr  = r.year;
      // bad month, year 0, year past the top, or a day the month lacks
      if (r.month < MONTH_JAN || r.month > MONTH_DEC || yr == 0 || yr > MAX_YEAR ||
          r.day == 0 || r.day > days_in_month(r.month, yr))
         return res;
      res.input_valid = 1'b1;
      doy = r.day;
      for (mo = MONTH_JAN; mo < r.month; mo++)
         doy += days_in_month(mo, yr);
      doy += r.days_to_add;
      // peel whole years; running past MAX_YEAR flags overflow
      while (doy > days_in_year(yr)) begin
         doy -= days_in_year(yr);
         yr++;
         if (yr > MAX_YEAR) begin
            res.overflow = 1'b1;
            return res;
         end
      end
      mo = MONTH_JAN;
      while (mo < MONTH_DEC && doy > days_in_month(mo, yr)) begin
         doy -= days_in_month(mo, yr);
         mo++;
      end
      res.out_day   = doy[4:0];
      res.out_month = mo;
      res.out_year  = yr[YEAR_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: every strobe must match the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type exp_date;
      if (!reset && rsp_valid === 1'b1) begin
         if (later_dates.size() == 0) begin
            error_count++;
            if (mismatch_count < MAX_REPORTS)
               $display("ERROR: result with nothing expected:",
                        " day %0d month %0d year %0d valid %0b ovf %0b",
                        rsp_item.out_day, rsp_item.out_month, rsp_item.out_year,
                        rsp_item.input_valid, rsp_item.overflow);
            mismatch_count++;
         end else begin
            exp_date = later_dates.pop_front();
            if (rsp_item.out_day !== exp_date.out_day ||
                rsp_item.out_month !== exp_date.out_month ||
                rsp_item.out_year !== exp_date.out_year ||
                rsp_item.input_valid !== exp_date.input_valid ||
                rsp_item.overflow !== exp_date.overflow) begin
               error_count++;
               if (mismatch_count < MAX_REPORTS)
                  $display("ERROR: mismatch exp day %0d month %0d year %0d valid %0b ovf %0b",
                           exp_date.out_day, exp_date.out_month, exp_date.out_year,
                           exp_date.input_valid, exp_date.overflow,
                           " / got day %0d month %0d year %0d valid %0b ovf %0b",
                           rsp_item.out_day, rsp_item.out_month, rsp_item.out_year,
                           rsp_item.input_valid, rsp_item.overflow);
               mismatch_count++;
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sender side: all tasks enter and leave on a falling edge
   // ---------------------------------------------------------------------
   // Hold one item on the port until an edge sees start high and busy low.
   // start is left high so a back-to-back item needs no second assignment.
   task automatic send_date(input req_type r);
      start    <= 1'b1;
      req_item <= r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      later_dates.push_back(predict_later_date(r));
      @(negedge clock);
   endtask

   // Sender gap; the request bus carries junk meanwhile.
   task automatic pause_sender(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) begin
         req_item <= req_type'(REQ_W'({$urandom, $urandom}));
         @(negedge clock);
      end
   endtask

   // Random burst of idling, roughly every third item.
   task automatic maybe_idle();
      if ($urandom_range(0, 2) == 0)
         pause_sender($urandom_range(1, 11));
   endtask

   // Stop sending and let every owed result come back.
   task automatic wait_for_results();
      start <= 1'b0;
      while (later_dates.size() != 0)
         @(negedge clock);
   endtask

   function automatic req_type make_date(input int unsigned d, input int unsigned m,
                                         input int unsigned y, input int unsigned add);
      req_type r;
      r.day         = d[4:0];
      r.month       = m[3:0];
      r.year        = y[YEAR_W-1:0];
      r.days_to_add = add[ADD_W-1:0];
      return r;
   endfunction

   // A valid start date; a quarter of them sit just below MAX_YEAR so the
   // year loop can run off the end.
   function automatic req_type random_valid_date();
      req_type     r;
      int unsigned yr;
      logic [3:0]  mo;
      mo = 4'($urandom_range(1, 12));
      yr = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_YEAR - 12, MAX_YEAR)
                                       : $urandom_range(1, MAX_YEAR);
      r.month = mo;
      r.year  = yr[YEAR_W-1:0];
      r.day   = 5'($urandom_range(1, days_in_month(mo, yr)));
      // mostly short hops; one in eight uses the whole 20-bit count
      if ($urandom_range(0, 7) == 0)
         r.days_to_add = ADD_W'($urandom);
      else
         r.days_to_add = ADD_W'($urandom_range(0, 2000));
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Field extremes, leap rules, each kind of invalid date, overflow.
   task automatic test_directed_dates();
      send_date(make_date(1, 1, 1, 0));              // earliest date
      send_date(make_date(31, 12, MAX_YEAR, 0));     // last date, no move
      send_date(make_date(31, 12, MAX_YEAR, 1));     // one step past the top
      send_date(make_date(1, 1, 8000, 1048575));     // full count runs off the end
      maybe_idle();
      send_date(make_date(1, 1, 1, 1048575));        // full count, stays in range
      send_date(make_date(29, 2, 2000, 0));          // century leap year
      send_date(make_date(29, 2, 1900, 0));          // century non-leap: invalid
      send_date(make_date(29, 2, 2024, 0));          // plain leap year
      send_date(make_date(29, 2, 2023, 0));          // plain common year: invalid
      pause_sender(3);
      send_date(make_date(28, 2, 2100, 1));          // lands on Mar 1
      send_date(make_date(31, 12, 1999, 1));         // year rollover
      send_date(make_date(1, 1, 2000, 365));         // Dec 31 of a leap year
      send_date(make_date(0, 1, 2000, 5));           // day 0
      send_date(make_date(31, 4, 2001, 5));          // day past a 30-day month
      send_date(make_date(30, 11, 2001, 40));        // last day of a 30-day month
      send_date(make_date(15, 0, 2001, 5));          // month 0
      send_date(make_date(15, 13, 2001, 5));         // month just past December
      send_date(make_date(31, 15, 16383, 1048575));  // every field at its top
      send_date(make_date(1, 8, 0, 0));              // year 0
      send_date(make_date(1, 8, MAX_YEAR + 1, 0));   // year just past the top
      send_date(make_date(31, 1, 4, 59));            // across a leap February to Mar 30
      wait_for_results();
   endtask

   // Mostly valid dates with random hops, some raw noise; idle gaps in
   // alternate stretches, a full drain midway, then a gap-free tail.
   task automatic test_random_dates();
      req_type r;
      for (int n = 0; n < 120; n++) begin
         if ($urandom_range(0, 7) == 0)
            r = req_type'(REQ_W'({$urandom, $urandom}));
         else
            r = random_valid_date();
         send_date(r);
         if (n == 60)
            wait_for_results();
         // stretches of 20 items alternate between gappy and gap-free
         if (n < 110 && ((n / 20) % 2 == 0))
            maybe_idle();
      end
      wait_for_results();
   endtask

   initial begin
      mismatch_count = 0;
      error_count    = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_dates();
      test_random_dates();

      // catch any stray strobe after the last result
      repeat (100) @(negedge clock);
      if (error_count == 0 && later_dates.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[gregorian_date_add_days.f]
src/gda_pkg.sv
src/gregorian_date_add_days.sv
dv/gregorian_date_add_days_test.sv
